// ===== rtl/lcg_xor_header_descrambler_unit_assert.svh =====
`ifndef LCG_XOR_HEADER_DESCRAMBLER_UNIT_ASSERT_SVH
`define LCG_XOR_HEADER_DESCRAMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LXHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lxhd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LXHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lxhd next-cycle check failed");

`endif

// ===== rtl/lxhd_pkg.sv =====
`default_nettype none

package lxhd_pkg;

    localparam int unsigned BLOCK_BYTES = 256;
    localparam logic [7:0]  LAST_POS    = 8'(BLOCK_BYTES - 1);

    localparam logic [31:0] LCG_MUL     = 32'd214013;
    localparam logic [31:0] LCG_INC     = 32'd2531011;

    localparam logic [4:0]  FIELD_BASE  = 5'd4;
    localparam logic [7:0]  SEED_BYTES  = 8'd4;
    localparam logic [7:0]  KEY_BYTES   = 8'd16;
    localparam logic [7:0]  HASH_END    = 8'd80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN_MASK,
        ST_GEN_LEN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        TAG_SEED,
        TAG_SKIP,
        TAG_KEY_HASH,
        TAG_HASH_ONLY,
        TAG_OPTION,
        TAG_TRAILER
    } tag_t;

    // One MSVC rand step, mod 2^32.
    function automatic logic [31:0] lcg_step(input logic [31:0] s);
        lcg_step = s * LCG_MUL + LCG_INC;
    endfunction

    function automatic tag_t tag_of(input logic [7:0] pos, input logic [4:0] fs);
        logic [7:0] fs8;
        fs8 = {3'b000, fs};
        if (pos < SEED_BYTES)
            tag_of = TAG_SEED;
        else if (pos < fs8)
            tag_of = TAG_SKIP;
        else if (pos < fs8 + KEY_BYTES)
            tag_of = TAG_KEY_HASH;
        else if (pos < fs8 + HASH_END)
            tag_of = TAG_HASH_ONLY;
        else if (pos == fs8 + HASH_END)
            tag_of = TAG_OPTION;
        else
            tag_of = TAG_TRAILER;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcg_xor_header_descrambler_unit.sv =====
// Inside a run an accepted byte goes through ST_EMIT into the output register; a byte that
// opens a run first takes two LCG steps (ST_GEN_MASK, ST_GEN_LEN) through the one shared multiply-add unit.
// No new byte is accepted until the current one is emitted; out_stall can hold ST_EMIT.
// Reset (rst_n, async, active low): seed 0, generator 0, position 0, field start 4,
// no output pending.
`default_nettype none

`include "lcg_xor_header_descrambler_unit_assert.svh"

module lcg_xor_header_descrambler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write channel: seed
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // input byte channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    // output byte channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [7:0]       position,
    output logic [2:0]       field_tag,
    output logic             last
);
    import lxhd_pkg::*;

    // Sequencer and control state
    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] gen_reg;          // LCG state, stepped in ST_GEN_MASK and ST_GEN_LEN
    logic [7:0]  mask_reg;         // XOR byte of the current run
    logic [4:0]  run_reg;          // bytes left in current run
    logic [7:0]  pos_reg;          // position of the next input byte
    logic [4:0]  fstart_reg;       // start offset from byte zero
    logic        out_valid_reg;

    // Held input byte and output payload
    logic [7:0]  data_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_pos_reg;
    logic [2:0]  out_tag_reg;
    logic        out_last_reg;

    // Shared unit: one multiply-add per cycle
    logic [31:0] step_val;
    logic        in_xfer;
    logic        emit_fire;
    logic        need_gen;
    logic        is_last;

    assign step_val  = lcg_step(gen_reg);
    assign in_xfer   = in_valid && !in_stall;
    // a new run starts at block start or when the old run is used up
    assign need_gen  = (pos_reg == 8'd0) || (run_reg == 5'd0);
    assign is_last   = (pos_reg == LAST_POS);

    // Seed is always writable; it only takes effect at position zero.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = need_gen ? ST_GEN_MASK : ST_EMIT;
            end
            ST_GEN_MASK: state_next = ST_GEN_LEN;
            ST_GEN_LEN:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        emit_fire = 1'b0;
        case (state_reg)
            ST_IDLE:     in_stall  = 1'b0;
            ST_GEN_MASK: in_stall  = 1'b1;
            ST_GEN_LEN:  in_stall  = 1'b1;
            ST_EMIT:     emit_fire = !out_valid_reg || !out_stall;
            default:     in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            gen_reg       <= '0;
            mask_reg      <= '0;
            run_reg       <= '0;
            pos_reg       <= '0;
            fstart_reg    <= FIELD_BASE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                seed_reg <= cfg_data;

            if (in_xfer && (pos_reg == 8'd0))
            begin
                gen_reg    <= seed_reg;
                run_reg    <= '0;
                fstart_reg <= FIELD_BASE + {1'b0, data_byte[3:0]};
            end

            if (state_reg == ST_GEN_MASK)
            begin
                gen_reg  <= step_val;
                mask_reg <= step_val[23:16];
            end

            if (state_reg == ST_GEN_LEN)
            begin
                gen_reg <= step_val;
                run_reg <= {1'b0, step_val[19:16]} + 5'd1;
            end

            if (emit_fire)
            begin
                run_reg       <= run_reg - 5'd1;
                pos_reg       <= is_last ? 8'd0 : pos_reg + 8'd1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            data_reg <= data_byte;
        if (emit_fire)
        begin
            out_byte_reg <= (pos_reg < SEED_BYTES) ? data_reg : (data_reg ^ mask_reg);
            out_pos_reg  <= pos_reg;
            out_tag_reg  <= tag_of(pos_reg, fstart_reg);
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign position  = out_pos_reg;
    assign field_tag = out_tag_reg;
    assign last      = out_last_reg;

    `LXHD_ASSERT_NEXT(a_xfer_leaves_idle, clk, rst_n, in_xfer, state_reg != ST_IDLE)
    `LXHD_ASSERT_NEXT(a_mask_then_len, clk, rst_n, state_reg == ST_GEN_MASK,
        state_reg == ST_GEN_LEN)
    `LXHD_ASSERT_NOW(a_last_at_end, clk, rst_n, out_valid_reg,
        out_last_reg == (out_pos_reg == LAST_POS))
    `LXHD_ASSERT_NOW(a_seed_tag, clk, rst_n, out_valid_reg,
        (out_tag_reg == TAG_SEED) == (out_pos_reg < SEED_BYTES))
    `LXHD_ASSERT_NOW(a_run_live_on_emit, clk, rst_n, state_reg == ST_EMIT,
        run_reg != 5'd0)

endmodule

`default_nettype wire
